### sv/hvd_pkg.sv
package hvd_pkg;

  localparam int CHAN_W              = 8;
  localparam int N_W                 = 11;  // holds six times a channel difference
  localparam int FRAC_BITS           = 16;
  localparam int Q16_W               = FRAC_BITS + 1;
  localparam int VQ_W                = 16;
  localparam int DIV_STEPS_PER_STAGE = 4;
  localparam int DIV_STAGES          = FRAC_BITS / DIV_STEPS_PER_STAGE;
  localparam int FRONT_STAGES        = 2;
  localparam int BACK_STAGES         = 3;
  localparam int NUM_STAGES          = FRONT_STAGES + DIV_STAGES + BACK_STAGES;

  localparam logic [Q16_W-1:0] ONE_Q16    = 17'h10000;
  localparam logic [VQ_W-1:0]  CLAMP_Q8_8 = 16'd652;

  typedef struct packed {
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
  } pixel_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
  } pixel_out_t;

  // Hue sectors, 60 degrees each
  typedef enum logic [2:0] {
    SEC_R_Y = 3'd0,
    SEC_Y_G = 3'd1,
    SEC_G_C = 3'd2,
    SEC_C_B = 3'd3,
    SEC_B_M = 3'd4,
    SEC_M_R = 3'd5
  } sector_t;

  // Per-pixel data that rides along the divider
  typedef struct packed {
    pixel_in_t         pix;
    logic              bypass;
    sector_t           sector;
    logic [VQ_W-1:0]   vq;
    logic              dz;
  } side_t;

  // One restoring-division lane: partial remainder, divisor, quotient so far
  typedef struct packed {
    logic [CHAN_W-1:0] rem;
    logic [CHAN_W-1:0] den;
    logic [Q16_W-1:0]  quo;
  } div_lane_t;

  typedef struct packed {
    side_t     side;
    div_lane_t sat_lane;
    div_lane_t frac_lane;
  } div_bundle_t;

  // One quotient bit: double the remainder, subtract the divisor if it fits.
  // The remainder stays below the divisor, so the doubled value needs one extra bit.
  function automatic div_lane_t div_step(input div_lane_t l);
    div_lane_t         o;
    logic [CHAN_W:0]   t;
    logic [CHAN_W:0]   dn;
    o  = l;
    t  = {l.rem, 1'b0};
    dn = {1'b0, l.den};
    if (t >= dn) begin
      o.rem = CHAN_W'(t - dn);
      o.quo = {l.quo[Q16_W-2:0], 1'b1};
    end else begin
      o.rem = t[CHAN_W-1:0];
      o.quo = {l.quo[Q16_W-2:0], 1'b0};
    end
    div_step = o;
  endfunction

endpackage

### sv/hvd_front.sv
module hvd_front (
  input  logic                          clk,
  input  logic [hvd_pkg::FRONT_STAGES-1:0] en,
  input  logic [hvd_pkg::CHAN_W-1:0]    dim_amount,
  input  hvd_pkg::pixel_in_t            pixel,
  output hvd_pkg::div_bundle_t          bundle
);
  import hvd_pkg::*;

  // stage 1: max, min, spread and hue numerator
  pixel_in_t          pix1;
  logic               bypass1;
  logic [N_W-1:0]     n1;
  logic [CHAN_W-1:0]  d1;
  logic [CHAN_W-1:0]  mx1;

  logic [CHAN_W-1:0]  r, g, b, mx, mn, d;
  logic [N_W-1:0]     d_w, n;

  always_comb begin
    r   = pixel.red_in;
    g   = pixel.green_in;
    b   = pixel.blue_in;
    mx  = r;
    mn  = r;
    d   = '0;
    d_w = '0;
    n   = '0;
    priority if (r >= g && r >= b) begin
      mx = r;
      mn = (g < b) ? g : b;
    end else if (g >= b) begin
      mx = g;
      mn = (r < b) ? r : b;
    end else begin
      mx = b;
      mn = (r < g) ? r : g;
    end
    d   = mx - mn;
    d_w = {{(N_W-CHAN_W){1'b0}}, d};
    priority if (r >= g && r >= b) begin
      if (g >= b) n = {{(N_W-CHAN_W){1'b0}}, g - b};
      else        n = (d_w << 2) + (d_w << 1) + {{(N_W-CHAN_W){1'b0}}, g}
                      - {{(N_W-CHAN_W){1'b0}}, b};
    end else if (g >= b) begin
      n = (d_w << 1) + {{(N_W-CHAN_W){1'b0}}, b} - {{(N_W-CHAN_W){1'b0}}, r};
    end else begin
      n = (d_w << 2) + {{(N_W-CHAN_W){1'b0}}, r} - {{(N_W-CHAN_W){1'b0}}, g};
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pix1    <= pixel;
      bypass1 <= (dim_amount == '0) || ((pixel.red_in | pixel.green_in | pixel.blue_in) == '0);
      n1      <= n;
      d1      <= d;
      mx1     <= mx;
    end
  end

  // stage 2: sector, remainder, value and the top bit of saturation
  logic [N_W-1:0]     dd, d2x, d3x, d4x, d5x;
  sector_t            sector;
  logic [N_W-1:0]     rem_w;
  logic [VQ_W-1:0]    vq;
  div_bundle_t        nxt;

  always_comb begin
    dd  = {{(N_W-CHAN_W){1'b0}}, d1};
    d2x = dd << 1;
    d3x = d2x + dd;
    d4x = dd << 2;
    d5x = d4x + dd;
    priority if (d1 == '0) begin
      sector = SEC_R_Y;
      rem_w  = '0;
    end else if (n1 >= d5x) begin
      sector = SEC_M_R;
      rem_w  = n1 - d5x;
    end else if (n1 >= d4x) begin
      sector = SEC_B_M;
      rem_w  = n1 - d4x;
    end else if (n1 >= d3x) begin
      sector = SEC_C_B;
      rem_w  = n1 - d3x;
    end else if (n1 >= d2x) begin
      sector = SEC_G_C;
      rem_w  = n1 - d2x;
    end else if (n1 >= dd) begin
      sector = SEC_Y_G;
      rem_w  = n1 - dd;
    end else begin
      sector = SEC_R_Y;
      rem_w  = n1;
    end

    if (mx1 < dim_amount) vq = CLAMP_Q8_8;
    else                  vq = {mx1 - dim_amount, 8'h00};

    nxt.side.pix    = pix1;
    nxt.side.bypass = bypass1;
    nxt.side.sector = sector;
    nxt.side.vq     = vq;
    nxt.side.dz     = (d1 == '0);

    // saturation d/max: first quotient bit is set only at full saturation
    nxt.sat_lane.den = mx1;
    if (d1 == mx1) begin
      nxt.sat_lane.rem = '0;
      nxt.sat_lane.quo = Q16_W'(1);
    end else begin
      nxt.sat_lane.rem = d1;
      nxt.sat_lane.quo = '0;
    end

    // hue fraction rem/d: remainder is below d, so the first bit is zero
    nxt.frac_lane.den = d1;
    nxt.frac_lane.rem = rem_w[CHAN_W-1:0];
    nxt.frac_lane.quo = '0;
  end

  always_ff @(posedge clk) begin
    if (en[1]) bundle <= nxt;
  end

endmodule

### sv/hvd_div_stage.sv
module hvd_div_stage (
  input  logic                 clk,
  input  logic                 en,
  input  hvd_pkg::div_bundle_t din,
  output hvd_pkg::div_bundle_t dout
);
  import hvd_pkg::*;

  div_bundle_t nxt;

  // advance both lanes by a fixed number of quotient bits
  always_comb begin
    nxt = din;
    for (int k = 0; k < DIV_STEPS_PER_STAGE; k++) begin
      nxt.sat_lane  = div_step(nxt.sat_lane);
      nxt.frac_lane = div_step(nxt.frac_lane);
    end
  end

  always_ff @(posedge clk) begin
    if (en) dout <= nxt;
  end

endmodule

### sv/hvd_back.sv
module hvd_back (
  input  logic                            clk,
  input  logic [hvd_pkg::BACK_STAGES-1:0] en,
  input  hvd_pkg::div_bundle_t            bundle,
  output hvd_pkg::pixel_out_t             result
);
  import hvd_pkg::*;

  // stage A: f*S and (1-f)*S, then the three scale factors
  side_t              side_a;
  logic [Q16_W-1:0]   fac_p, fac_q, fac_t;

  logic [FRAC_BITS-1:0] frac;
  logic [Q16_W-1:0]     sat, one_minus_frac;
  logic [2*Q16_W-2:0]   prod_fs;
  logic [2*Q16_W-1:0]   prod_gs;

  always_comb begin
    frac           = bundle.side.dz ? '0 : bundle.frac_lane.quo[FRAC_BITS-1:0];
    sat            = bundle.side.dz ? '0 : bundle.sat_lane.quo;
    one_minus_frac = ONE_Q16 - {1'b0, frac};
    prod_fs        = {{Q16_W{1'b0}}, frac} * {{(Q16_W-1){1'b0}}, sat};
    prod_gs        = {{Q16_W{1'b0}}, one_minus_frac} * {{Q16_W{1'b0}}, sat};
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      side_a <= bundle.side;
      fac_p  <= ONE_Q16 - sat;
      fac_q  <= ONE_Q16 - prod_fs[FRAC_BITS +: Q16_W];
      fac_t  <= ONE_Q16 - prod_gs[FRAC_BITS +: Q16_W];
    end
  end

  // stage B: scale the value by each factor
  side_t              side_b;
  logic [CHAN_W-1:0]  vb, pb, qb, tb;
  logic [2*Q16_W-2:0] prod_p, prod_q, prod_t;

  always_comb begin
    prod_p = {{Q16_W{1'b0}}, side_a.vq} * {{(Q16_W-1){1'b0}}, fac_p};
    prod_q = {{Q16_W{1'b0}}, side_a.vq} * {{(Q16_W-1){1'b0}}, fac_q};
    prod_t = {{Q16_W{1'b0}}, side_a.vq} * {{(Q16_W-1){1'b0}}, fac_t};
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      side_b <= side_a;
      vb     <= side_a.vq[VQ_W-1 -: CHAN_W];
      pb     <= prod_p[FRAC_BITS+CHAN_W +: CHAN_W];
      qb     <= prod_q[FRAC_BITS+CHAN_W +: CHAN_W];
      tb     <= prod_t[FRAC_BITS+CHAN_W +: CHAN_W];
    end
  end

  // stage C: route bytes by sector, or pass the pixel through
  pixel_out_t sel;

  always_comb begin
    unique case (side_b.sector)
      SEC_R_Y: sel = '{red_out: vb, green_out: tb, blue_out: pb};
      SEC_Y_G: sel = '{red_out: qb, green_out: vb, blue_out: pb};
      SEC_G_C: sel = '{red_out: pb, green_out: vb, blue_out: tb};
      SEC_C_B: sel = '{red_out: pb, green_out: qb, blue_out: vb};
      SEC_B_M: sel = '{red_out: tb, green_out: pb, blue_out: vb};
      default: sel = '{red_out: vb, green_out: pb, blue_out: qb};
    endcase
    if (side_b.bypass) begin
      sel = '{red_out:   side_b.pix.red_in,
              green_out: side_b.pix.green_in,
              blue_out:  side_b.pix.blue_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) result <= sel;
  end

endmodule

### sv/hsv_value_dimmer_unit.sv
// Channel   Signals                                          Direction
// pixel     pixel_valid / pixel_ready / pixel (red/green/blue_in)   in
// result    result_valid / result_ready / result (red/green/blue_out) out
// config    cfg_we / cfg_wdata (dim_amount)                  in
//
// One pixel per cycle sustained while result_ready stays high. The pipeline
// stages are two front stages, four divider stages of four quotient bits each,
// two multiply stages and the output register; the divider depth dominates.
// Reset clears the stage valid bits and dim_amount; payload is not reset.
// Each stage loads when it is empty or its successor moves, so bubbles
// collapse and a stalled result holds in the output register while the
// stages behind it keep filling. pixel_ready follows result_ready through
// that chain in the same cycle.
module hsv_value_dimmer_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [hvd_pkg::CHAN_W-1:0]  cfg_wdata,
  input  logic                        pixel_valid,
  output logic                        pixel_ready,
  input  hvd_pkg::pixel_in_t          pixel,
  output logic                        result_valid,
  input  logic                        result_ready,
  output hvd_pkg::pixel_out_t         result
);
  import hvd_pkg::*;

  localparam int LAST = NUM_STAGES - 1;

  // dim amount register; to be written only while the pipe is empty, a rule the block leaves to the user
  logic [CHAN_W-1:0] dim_amount;

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_amount <= '0;
    end else if (cfg_we) begin
      dim_amount <= cfg_wdata;
    end
  end

  // Stage valid bits and load enables. A stage loads when it holds nothing
  // or when the stage after it moves on in this cycle.
  logic [NUM_STAGES-1:0] stage_valid;
  logic [NUM_STAGES-1:0] stage_valid_next;
  logic [NUM_STAGES-1:0] en;

  always_comb begin
    en[LAST] = !stage_valid[LAST] || result_ready;
    for (int i = LAST - 1; i >= 0; i--) begin
      en[i] = !stage_valid[i] || en[i+1];
    end
    stage_valid_next[0] = en[0] ? pixel_valid : stage_valid[0];
    for (int i = 1; i < NUM_STAGES; i++) begin
      stage_valid_next[i] = en[i] ? stage_valid[i-1] : stage_valid[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      stage_valid <= stage_valid_next;
    end
  end

  assign pixel_ready  = en[0];
  assign result_valid = stage_valid[LAST];

  // datapath: front analysis, divider chain, multiply and route
  div_bundle_t chain [DIV_STAGES+1];

  hvd_front u_front (
    .clk        (clk),
    .en         (en[FRONT_STAGES-1:0]),
    .dim_amount (dim_amount),
    .pixel      (pixel),
    .bundle     (chain[0])
  );

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    hvd_div_stage u_div (
      .clk  (clk),
      .en   (en[FRONT_STAGES+s]),
      .din  (chain[s]),
      .dout (chain[s+1])
    );
  end

  hvd_back u_back (
    .clk    (clk),
    .en     (en[LAST -: BACK_STAGES]),
    .bundle (chain[DIV_STAGES]),
    .result (result)
  );

endmodule

### sv/hvd_checker.sv
module hvd_assertions (
  input logic                        clk,
  input logic                        rst,
  input logic                        pixel_valid,
  input logic                        pixel_ready,
  input hvd_pkg::pixel_in_t          pixel,
  input logic                        result_valid,
  input logic                        result_ready,
  input hvd_pkg::pixel_out_t         result
);
  import hvd_pkg::*;

  // a waiting pixel stays put
  a_pixel_hold: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && !pixel_ready |=> pixel_valid && $stable(pixel))
    else $error("pixel changed while waiting");

  // a stalled result stays put
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  // an empty output register never blocks intake
  a_empty_takes: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> pixel_ready)
    else $error("input blocked with empty output");

  // a draining output lets every stage advance
  a_drain_takes: assert property (@(posedge clk) disable iff (rst)
    result_ready |-> pixel_ready)
    else $error("input blocked while output drains");

endmodule

bind hsv_value_dimmer_unit hvd_assertions u_checker (.*);

### test/hvd_checker.sv
`timescale 1ns / 1ps

module hvd_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [hvd_pkg::CHAN_W-1:0] cfg_wdata,
  input  logic                       pixel_valid,
  input  logic                       pixel_ready,
  input  hvd_pkg::pixel_in_t         pixel,
  input  logic                       result_valid,
  input  logic                       result_ready,
  input  hvd_pkg::pixel_out_t        result,
  output int                         mismatches,
  output int                         outstanding,
  output int                         pixels_checked,
  output int                         clamp_hits
);
  import hvd_pkg::*;

  logic [CHAN_W-1:0] dim_shadow;
  pixel_out_t        dimmed_queue[$];
  int                err_count;
  int                check_count;
  int                clamp_count;

  // Truncating Q8.8 x Q1.16 scale down to one channel byte.
  function automatic logic [CHAN_W-1:0] scale_value(input logic [VQ_W-1:0] vq,
                                                    input logic [Q16_W-1:0] k);
    return CHAN_W'((64'(vq) * k) >> 24);
  endfunction

  function automatic pixel_out_t dim_pixel(input pixel_in_t px, input logic [CHAN_W-1:0] dim);
    logic [CHAN_W-1:0] r, g, b, mx, mn, dif;
    logic [N_W-1:0]    hue_num;
    sector_t           sec;
    logic [Q16_W-1:0]  frac, sat, fs, gs;
    logic [VQ_W-1:0]   vq;
    logic [CHAN_W-1:0] vb, pb, qb, tb;
    pixel_out_t        o;
    r = px.red_in;
    g = px.green_in;
    b = px.blue_in;
    if (dim == '0 || (r | g | b) == '0) begin
      o.red_out   = r;
      o.green_out = g;
      o.blue_out  = b;
      return o;
    end
    // red wins ties, then green
    if (r >= g && r >= b) begin
      mx      = r;
      mn      = (g < b) ? g : b;
      dif     = mx - mn;
      hue_num = (g >= b) ? N_W'(g - b) : N_W'(32'(dif) * 6 - 32'(b - g));
    end else if (g >= r && g >= b) begin
      mx      = g;
      mn      = (r < b) ? r : b;
      dif     = mx - mn;
      hue_num = N_W'(32'(dif) * 2 + 32'(b) - 32'(r));
    end else begin
      mx      = b;
      mn      = (r < g) ? r : g;
      dif     = mx - mn;
      hue_num = N_W'(32'(dif) * 4 + 32'(r) - 32'(g));
    end
    if (dif == '0) begin
      sec  = SEC_R_Y;
      frac = '0;
      sat  = '0;
    end else begin
      sec  = sector_t'(3'((32'(hue_num) / dif) % 6));
      frac = Q16_W'((32'(hue_num) % dif << FRAC_BITS) / dif);
      sat  = Q16_W'((32'(dif) << FRAC_BITS) / mx);
    end
    vq = (mx < dim) ? CLAMP_Q8_8 : {mx - dim, 8'h00};
    fs = Q16_W'((64'(frac) * sat) >> FRAC_BITS);
    gs = Q16_W'((64'(ONE_Q16 - frac) * sat) >> FRAC_BITS);
    vb = vq[VQ_W-1:8];
    pb = scale_value(vq, ONE_Q16 - sat);
    qb = scale_value(vq, ONE_Q16 - fs);
    tb = scale_value(vq, ONE_Q16 - gs);
    case (sec)
      SEC_R_Y: begin o.red_out = vb; o.green_out = tb; o.blue_out = pb; end
      SEC_Y_G: begin o.red_out = qb; o.green_out = vb; o.blue_out = pb; end
      SEC_G_C: begin o.red_out = pb; o.green_out = vb; o.blue_out = tb; end
      SEC_C_B: begin o.red_out = pb; o.green_out = qb; o.blue_out = vb; end
      SEC_B_M: begin o.red_out = tb; o.green_out = pb; o.blue_out = vb; end
      default: begin o.red_out = vb; o.green_out = pb; o.blue_out = qb; end
    endcase
    return o;
  endfunction

  initial begin
    err_count   = 0;
    check_count = 0;
    clamp_count = 0;
    dim_shadow  = '0;
  end

  always @(posedge clk) begin : watch_channels
    pixel_out_t        want;
    logic [CHAN_W-1:0] peak;
    if (rst) begin
      dim_shadow = '0;
      dimmed_queue.delete();
    end else begin
      if (pixel_valid && pixel_ready) begin
        dimmed_queue.push_back(dim_pixel(pixel, dim_shadow));
        peak = (pixel.red_in > pixel.green_in) ? pixel.red_in : pixel.green_in;
        peak = (peak > pixel.blue_in) ? peak : pixel.blue_in;
        if (dim_shadow != '0 && peak != '0 && peak < dim_shadow)
          clamp_count++;
      end
      if (cfg_we)
        dim_shadow = cfg_wdata;
      if (result_valid && result_ready) begin
        if (dimmed_queue.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result r=%0d g=%0d b=%0d", $time,
                   result.red_out, result.green_out, result.blue_out);
        end else begin
          want = dimmed_queue.pop_front();
          check_count++;
          if (result.red_out !== want.red_out || result.green_out !== want.green_out ||
              result.blue_out !== want.blue_out) begin
            err_count++;
            $display("%0t: mismatch expected r=%0d g=%0d b=%0d actual r=%0d g=%0d b=%0d",
                     $time, want.red_out, want.green_out, want.blue_out,
                     result.red_out, result.green_out, result.blue_out);
          end
        end
      end
    end
    mismatches     <= err_count;
    outstanding    <= dimmed_queue.size();
    pixels_checked <= check_count;
    clamp_hits     <= clamp_count;
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import hvd_pkg::*;

  logic              clk;
  logic              rst          = 1'b1;
  logic              cfg_we       = 1'b0;
  logic [CHAN_W-1:0] cfg_wdata    = '0;
  logic              pixel_valid  = 1'b0;
  logic              pixel_ready;
  pixel_in_t         pixel        = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  pixel_out_t        result;

  int mismatches;
  int outstanding;
  int pixels_checked;
  int clamp_hits;

  // Sink-side stall state and source pacing mode
  int stall_left    = 0;
  bit sink_steady   = 1'b0;
  bit source_steady = 1'b0;
  int dims_tried    = 0;

  hsv_value_dimmer_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  hvd_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .pixel_valid    (pixel_valid),
    .pixel_ready    (pixel_ready),
    .pixel          (pixel),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .result         (result),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .pixels_checked (pixels_checked),
    .clamp_hits     (clamp_hits)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run (every transaction hit by
  // a long source gap and a long sink stall on top of the pipeline depth).
  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    if ($urandom_range(0, 19) == 0)
      return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic pixel_in_t rgb(input int r, input int g, input int b);
    pixel_in_t p;
    p.red_in   = CHAN_W'(r);
    p.green_in = CHAN_W'(g);
    p.blue_in  = CHAN_W'(b);
    return p;
  endfunction

  // Random pixel shaped around the current dim amount: plain random bytes
  // for bit coverage, peaks near the dim amount to hit the zero and clamp
  // edges, grays and ties for the hue tie-break, and fully saturated hues.
  function automatic pixel_in_t rand_pixel(input int dim);
    int                kind;
    int                peak;
    int                top_ch;
    int                v;
    logic [CHAN_W-1:0] c[3];
    kind   = $urandom_range(0, 9);
    top_ch = $urandom_range(0, 2);
    for (int i = 0; i < 3; i++)
      c[i] = CHAN_W'($urandom);
    case (kind)
      5, 6: begin
        peak = dim + $urandom_range(0, 4) - 2;
        if (peak < 0)   peak = 0;
        if (peak > 255) peak = 255;
        for (int i = 0; i < 3; i++)
          c[i] = CHAN_W'($urandom_range(0, peak));
        c[top_ch] = CHAN_W'(peak);
      end
      7: begin
        v = $urandom_range(0, 255);
        c[0] = CHAN_W'(v);
        c[1] = CHAN_W'(v);
        if ($urandom_range(0, 1) == 0)
          c[2] = CHAN_W'(v);
      end
      8: begin
        c[top_ch]           = 8'hff;
        c[(top_ch + 1) % 3] = 8'h00;
      end
      9: begin
        if ($urandom_range(0, 1) == 0) begin
          c[0] = '0; c[1] = '0; c[2] = '0;
        end else begin
          c[0] = '1; c[1] = '1; c[2] = '1;
        end
      end
      default: ;
    endcase
    // rotate so each channel gets every role
    v = $urandom_range(0, 2);
    return rgb(c[v], c[(v + 1) % 3], c[(v + 2) % 3]);
  endfunction

  // Sink: hold ready low for random stalls, with steady stretches.
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (stall_left > 0) begin
      result_ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      result_ready <= 1'b1;
      if (!sink_steady && $urandom_range(0, 5) == 0)
        stall_left <= pick_gap();
      if ($urandom_range(0, 299) == 0)
        sink_steady <= ~sink_steady;
    end
  end

  // Present one pixel, hold it until the transaction completes, then maybe idle.
  task automatic send_pixel(input pixel_in_t p);
    pixel       <= p;
    pixel_valid <= 1'b1;
    do @(posedge clk); while (!pixel_ready);
    if ($urandom_range(0, 149) == 0)
      source_steady = ~source_steady;
    if (!source_steady && $urandom_range(0, 3) == 0) begin
      pixel_valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every expected result has been taken.
  task automatic wait_idle();
    pixel_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Write dim_amount; only called with the pipeline empty.
  task automatic set_dim(input int dim);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= CHAN_W'(dim);
    @(posedge clk);
    cfg_we    <= 1'b0;
    dims_tried++;
  endtask

  task automatic run_phase(input int dim, input int count, input bit drain_mid);
    set_dim(dim);
    for (int i = 0; i < count; i++) begin
      send_pixel(rand_pixel(dim));
      if (drain_mid && i == count / 2)
        wait_idle();
    end
  endtask

  initial begin : stimulus
    int phase_dims[9];
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset value of dim_amount is zero: everything must pass through.
    send_pixel(rgb(0, 0, 0));
    send_pixel(rgb(255, 255, 255));
    send_pixel(rgb(12, 200, 77));
    send_pixel(rgb(255, 0, 255));

    // Hue sectors, ties, gray, black, exact-zero value and the clamp.
    set_dim(40);
    send_pixel(rgb(0, 0, 0));
    send_pixel(rgb(255, 255, 255));
    send_pixel(rgb(100, 100, 100));
    send_pixel(rgb(255, 0, 0));
    send_pixel(rgb(200, 120, 10));
    send_pixel(rgb(120, 200, 10));
    send_pixel(rgb(10, 200, 120));
    send_pixel(rgb(10, 120, 200));
    send_pixel(rgb(120, 10, 200));
    send_pixel(rgb(200, 10, 120));
    send_pixel(rgb(180, 180, 20));
    send_pixel(rgb(30, 150, 150));
    send_pixel(rgb(150, 30, 150));
    send_pixel(rgb(40, 10, 0));
    send_pixel(rgb(30, 5, 20));

    // Largest dim amount: only a full-scale peak avoids the clamp.
    set_dim(255);
    send_pixel(rgb(255, 1, 254));
    send_pixel(rgb(254, 0, 1));
    send_pixel(rgb(1, 0, 0));

    // Random part: extremes first, then random settings.
    phase_dims = '{1, 255, 128, 0, 254, 0, 0, 0, 0};
    for (int k = 5; k < 9; k++)
      phase_dims[k] = $urandom_range(1, 255);
    for (int k = 0; k < 9; k++)
      run_phase(phase_dims[k], 190, k == 2);

    wait_idle();
    // let any stray extra result surface before the verdict
    repeat (20) @(posedge clk);
    $display("checked %0d pixels over %0d dim settings, %0d of them below the dim amount",
             pixels_checked, dims_tried, clamp_hits);
    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### files.f
sv/hvd_pkg.sv
sv/hvd_front.sv
sv/hvd_div_stage.sv
sv/hvd_back.sv
sv/hsv_value_dimmer_unit.sv
sv/hvd_checker.sv
test/hvd_checker.sv
test/tb_top.sv
